@@ sv/tcss_pkg.sv @@
package tcss_pkg;

  localparam int MaxItems = 32;
  localparam int MaxSum   = 1023;
  localparam int ValW     = 10;
  localparam int WordW    = 64;
  localparam int BitW     = $clog2(WordW);
  localparam int RowWords = (MaxSum + WordW) / WordW;
  localparam int WordIdxW = $clog2(RowWords);
  localparam int CountW   = $clog2(MaxItems + 1);
  localparam int ItemIdxW = $clog2(MaxItems);
  localparam int MemDepth = MaxItems * RowWords;
  localparam int AddrW    = $clog2(MemDepth);

  typedef logic [WordW-1:0] word_t;
  typedef logic [ValW-1:0]  val_t;

  typedef enum logic [1:0] {
    VerdictNo  = 2'd0,
    VerdictYes = 2'd1,
    VerdictOvf = 2'd2
  } verdict_e;

  typedef enum logic {
    KindVerdict = 1'b0,
    KindChoice  = 1'b1
  } kind_e;

  typedef enum logic {
    ChoiceHeads = 1'b0,
    ChoiceTails = 1'b1
  } choice_e;

  // Source of a row read: stored word, forced zero, or the row-zero seed word
  typedef enum logic [1:0] {
    SrcMem  = 2'd0,
    SrcZero = 2'd1,
    SrcOne  = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    StIdle,
    StBuild,
    StDrain,
    StVerdict,
    StVerdictChk,
    StTbRead,
    StTbChk,
    StEmit
  } state_e;

  typedef struct packed {
    src_e             src;
    logic [AddrW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    rd_req_t          port_a;
    rd_req_t          port_b;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
  } mem_ctrl_t;

  typedef struct packed {
    logic                clear;
    logic                dv;
    logic [WordIdxW-1:0] word;
    logic [BitW-1:0]     sh_h;
    logic [BitW-1:0]     sh_t;
  } merge_ctrl_t;

  typedef struct packed {
    logic     valid;
    kind_e    kind;
    verdict_e verdict;
    choice_e  choice;
    logic     last;
  } emit_t;

endpackage

@@ sv/tcss_row_mem.sv @@
module tcss_row_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcss_pkg::mem_ctrl_t ctrl_i,
  input  tcss_pkg::word_t     wr_data_i,
  output tcss_pkg::word_t     rd_a_o,
  output tcss_pkg::word_t     rd_b_o
);
  import tcss_pkg::*;

  word_t mem [MemDepth];
  word_t raw_a_q, raw_b_q;
  src_e  sel_a_q, sel_b_q;

  function automatic word_t pick(input src_e sel, input word_t raw);
    word_t w;
    unique case (sel)
      SrcMem:  w = raw;
      SrcOne:  w = word_t'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    raw_a_q <= mem[ctrl_i.port_a.addr];
    raw_b_q <= mem[ctrl_i.port_b.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_a_q <= SrcZero;
      sel_b_q <= SrcZero;
    end else begin
      sel_a_q <= ctrl_i.port_a.src;
      sel_b_q <= ctrl_i.port_b.src;
    end
  end

  assign rd_a_o = pick(sel_a_q, raw_a_q);
  assign rd_b_o = pick(sel_b_q, raw_b_q);

endmodule

@@ sv/tcss_merge.sv @@
module tcss_merge (
  input  logic                  clk_i,
  input  tcss_pkg::merge_ctrl_t ctrl_i,
  input  tcss_pkg::val_t        lim_i,
  input  tcss_pkg::word_t       rd_a_i,
  input  tcss_pkg::word_t       rd_b_i,
  output tcss_pkg::word_t       wr_data_o
);
  import tcss_pkg::*;

  word_t               prev_a_q, prev_b_q;
  word_t               mask;
  logic [BitW:0]       amt_a, amt_b;
  logic [2*WordW-1:0]  cat_a, cat_b;
  logic [WordIdxW-1:0] lim_word;
  logic [BitW-1:0]     lim_bit;

  // Hold the previous source word of each port for the carry-in bits
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      prev_a_q <= '0;
      prev_b_q <= '0;
    end else if (ctrl_i.dv) begin
      prev_a_q <= rd_a_i;
      prev_b_q <= rd_b_i;
    end
  end

  assign amt_a = (BitW+1)'(WordW) - {1'b0, ctrl_i.sh_h};
  assign amt_b = (BitW+1)'(WordW) - {1'b0, ctrl_i.sh_t};
  assign cat_a = {rd_a_i, prev_a_q} >> amt_a;
  assign cat_b = {rd_b_i, prev_b_q} >> amt_b;

  assign lim_word = lim_i[ValW-1:BitW];
  assign lim_bit  = lim_i[BitW-1:0];

  // Drop sums above the limit
  always_comb begin
    priority if (ctrl_i.word < lim_word) begin
      mask = '1;
    end else if (ctrl_i.word == lim_word) begin
      mask = word_t'('1) >> (BitW'(WordW - 1) - lim_bit);
    end else begin
      mask = '0;
    end
  end

  assign wr_data_o = (cat_a[WordW-1:0] | cat_b[WordW-1:0]) & mask;

endmodule

@@ sv/tcss_ctrl.sv @@
module tcss_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcss_pkg::val_t        heads_value_i,
  input  tcss_pkg::val_t        tails_value_i,
  input  logic                  last_item_i,
  input  tcss_pkg::val_t        target_i,
  input  tcss_pkg::word_t       rd_a_i,
  output tcss_pkg::mem_ctrl_t   mem_o,
  output tcss_pkg::merge_ctrl_t merge_o,
  input  logic                  out_free_i,
  output tcss_pkg::emit_t       emit_o
);
  import tcss_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, row_q, i_q, e_idx_q;
  logic                ovf_q, last_q, dv_q;
  val_t                hv_q, tv_q, s_q;
  logic [ValW:0]       d_q;
  logic [WordIdxW-1:0] w_q, wdly_q;
  verdict_e            verdict_q;
  val_t                heads_q [MaxItems];
  val_t                tails_q [MaxItems];
  logic [MaxItems-1:0] choice_q;

  logic                accept, has_room, last_word, tb_hit, v_hit, emit_take;
  logic [CountW-1:0]   i_m1, e_m1;
  logic [ItemIdxW-1:0] tb_idx, st_idx;
  logic [WordIdxW:0]   idx_a, idx_b;
  logic [ValW:0]       diff;
  val_t                h_sel, t_sel, s_tails;

  // Map a row and a signed word index to a memory request; row zero is the seed
  function automatic rd_req_t read_req(input logic [CountW-1:0] row,
                                       input logic [WordIdxW:0] idx);
    rd_req_t           req;
    logic [CountW-1:0] row_m1;
    row_m1   = row - 1'b1;
    req.addr = {row_m1[ItemIdxW-1:0], idx[WordIdxW-1:0]};
    if (idx[WordIdxW]) begin
      req.src = SrcZero;
    end else if (row == '0) begin
      req.src = (idx == '0) ? SrcOne : SrcZero;
    end else begin
      req.src = SrcMem;
    end
    return req;
  endfunction

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;
  assign has_room   = count_q < CountW'(MaxItems);
  assign last_word  = (w_q == WordIdxW'(RowWords - 1));
  assign st_idx     = count_q[ItemIdxW-1:0];

  assign idx_a = {1'b0, w_q} - {1'b0, hv_q[ValW-1:BitW]};
  assign idx_b = {1'b0, w_q} - {1'b0, tv_q[ValW-1:BitW]};

  assign i_m1    = i_q - 1'b1;
  assign tb_idx  = i_m1[ItemIdxW-1:0];
  assign h_sel   = heads_q[tb_idx];
  assign t_sel   = tails_q[tb_idx];
  assign diff    = {1'b0, s_q} - {1'b0, h_sel};
  assign tb_hit  = !d_q[ValW] & rd_a_i[d_q[BitW-1:0]];
  assign s_tails = (s_q >= t_sel) ? s_q - t_sel : '0;
  assign v_hit   = rd_a_i[target_i[BitW-1:0]];

  assign e_m1      = e_idx_q - 1'b1;
  assign emit_take = emit_o.valid & out_free_i;

  always_comb begin
    emit_o.valid   = (state_q == StEmit);
    emit_o.kind    = (e_idx_q == '0) ? KindVerdict : KindChoice;
    emit_o.verdict = verdict_q;
    emit_o.choice  = (e_idx_q == '0) ? ChoiceHeads : choice_e'(choice_q[e_m1[ItemIdxW-1:0]]);
    emit_o.last    = (verdict_q != VerdictYes) || (e_idx_q == count_q);

    merge_o.clear = accept;
    merge_o.dv    = dv_q;
    merge_o.word  = wdly_q;
    merge_o.sh_h  = hv_q[BitW-1:0];
    merge_o.sh_t  = tv_q[BitW-1:0];
  end

  always_comb begin
    state_d        = state_q;
    mem_o.port_a   = '{src: SrcZero, addr: '0};
    mem_o.port_b   = '{src: SrcZero, addr: '0};
    mem_o.wr_en    = dv_q;
    mem_o.wr_addr  = {row_q[ItemIdxW-1:0], wdly_q};
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (has_room) begin
            state_d = StBuild;
          end else if (last_item_i) begin
            state_d = StVerdict;
          end
        end
      end
      StBuild: begin
        mem_o.port_a = read_req(row_q, idx_a);
        mem_o.port_b = read_req(row_q, idx_b);
        if (last_word) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = last_q ? StVerdict : StIdle;
      end
      StVerdict: begin
        if (ovf_q) begin
          state_d = StEmit;
        end else begin
          mem_o.port_a = read_req(count_q, {1'b0, target_i[ValW-1:BitW]});
          state_d      = StVerdictChk;
        end
      end
      StVerdictChk: begin
        state_d = (!v_hit || count_q == '0) ? StEmit : StTbRead;
      end
      StTbRead: begin
        if (!diff[ValW]) begin
          mem_o.port_a = read_req(i_m1, {1'b0, diff[ValW-1:BitW]});
        end
        state_d = StTbChk;
      end
      StTbChk: begin
        state_d = (i_m1 == '0) ? StEmit : StTbRead;
      end
      StEmit: begin
        if (emit_take && emit_o.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
      dv_q    <= 1'b0;
      w_q     <= '0;
      e_idx_q <= '0;
    end else begin
      state_q <= state_d;
      dv_q    <= (state_q == StBuild);
      if (accept) begin
        w_q <= '0;
        if (has_room) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (state_q == StBuild) begin
        w_q <= w_q + 1'b1;
      end
      if (state_q == StEmit) begin
        if (emit_take) begin
          e_idx_q <= e_idx_q + 1'b1;
          if (emit_o.last) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
      end else begin
        e_idx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wdly_q <= w_q;
    if (accept) begin
      row_q  <= count_q;
      hv_q   <= heads_value_i;
      tv_q   <= tails_value_i;
      last_q <= last_item_i;
      if (has_room) begin
        heads_q[st_idx] <= heads_value_i;
        tails_q[st_idx] <= tails_value_i;
      end
    end
    if (state_q == StVerdict && ovf_q) begin
      verdict_q <= VerdictOvf;
    end
    if (state_q == StVerdictChk) begin
      verdict_q <= v_hit ? VerdictYes : VerdictNo;
      s_q       <= target_i;
      i_q       <= count_q;
    end
    if (state_q == StTbRead) begin
      d_q <= diff;
    end
    if (state_q == StTbChk) begin
      choice_q[tb_idx] <= !tb_hit;
      s_q              <= tb_hit ? d_q[ValW-1:0] : s_tails;
      i_q              <= i_m1;
    end
  end

endmodule

@@ sv/two_choice_subset_sum.sv @@
// Two-choice subset-sum engine.
// Input channel (in_valid_i / in_ready_o): one request per item with its heads
// and tails value; last_item_i closes the set. Output channel (out_valid_o /
// out_ready_i): a verdict word, then on a reachable target one choice word per
// item in input order; last_result_o marks the final word of the set.
// cfg_we_i / cfg_wdata_i load the target sum; load it only while the block is
// idle. Each accepted item builds the next reachability row: 16 words of 64
// bits go through the shared shift-merge unit at one word per cycle, limited
// by the single write port of the row memory. The next item is taken only
// once the row is written and the sequencer is back in idle; a request that
// arrives while the set is full is taken and dropped, sets the overflow flag,
// and the next one can be taken in the following cycle. After the last item
// the verdict reads the target bit of the last row (no read when the set
// overflowed), on a reachable target the traceback reads one row per item,
// then one result word leaves per cycle while the receiver takes them.
// A stalled receiver holds the current word in the output register and the
// sequencer waits; once the last word is loaded a new set may start.
// Reset clears the sequencer, item count, overflow flag and target. Row zero
// is a fixed seed word rather than memory content, so no clearing pass runs.
module two_choice_subset_sum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  tcss_pkg::val_t cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcss_pkg::val_t heads_value_i,
  input  tcss_pkg::val_t tails_value_i,
  input  logic           last_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           result_kind_o,
  output logic [1:0]     verdict_o,
  output logic           choice_o,
  output logic           last_result_o
);
  import tcss_pkg::*;

  val_t        target_q;
  mem_ctrl_t   mem_ctrl;
  merge_ctrl_t merge_ctrl;
  emit_t       emit;
  word_t       rd_a, rd_b, wr_data;
  logic        out_free;

  // Target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  tcss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .heads_value_i (heads_value_i),
    .tails_value_i (tails_value_i),
    .last_item_i   (last_item_i),
    .target_i      (target_q),
    .rd_a_i        (rd_a),
    .mem_o         (mem_ctrl),
    .merge_o       (merge_ctrl),
    .out_free_i    (out_free),
    .emit_o        (emit)
  );

  tcss_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .wr_data_i (wr_data),
    .rd_a_o    (rd_a),
    .rd_b_o    (rd_b)
  );

  tcss_merge u_merge (
    .clk_i     (clk_i),
    .ctrl_i    (merge_ctrl),
    .lim_i     (target_q),
    .rd_a_i    (rd_a),
    .rd_b_i    (rd_b),
    .wr_data_o (wr_data)
  );

  // Output register: load a word whenever the slot is empty or being drained
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit.valid && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && out_free) begin
      result_kind_o <= emit.kind;
      verdict_o     <= emit.verdict;
      choice_o      <= emit.choice;
      last_result_o <= emit.last;
    end
  end

endmodule

@@ sv/tcss_checker.sv @@
module tcss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       result_kind_o,
  input logic [1:0] verdict_o,
  input logic       choice_o,
  input logic       last_result_o
);
  import tcss_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({result_kind_o, verdict_o, choice_o, last_result_o}))
    else $error("stalled result word changed");

  // No new set starts while a set still has words to deliver
  a_busy_mid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> !in_ready_o)
    else $error("input ready before the set was fully delivered");

  a_choice_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindChoice |-> verdict_o == VerdictYes)
    else $error("choice word without reachable verdict");

  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindVerdict && verdict_o != VerdictYes
      |-> last_result_o)
    else $error("failing verdict not marked last");

endmodule

bind two_choice_subset_sum tcss_checker u_tcss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .verdict_o     (verdict_o),
  .choice_o      (choice_o),
  .last_result_o (last_result_o)
);
